[hw/rtl/pls_pkg.sv]
package pls_pkg;

    // Fixed field widths of the request and response words
    localparam int MODE_W     = 3;
    localparam int POS_W      = 7;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 3;

    // Default list capacity
    localparam int CAPACITY_DEF = 64;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PRIOR  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd6;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_NEIGHBOUR = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value_in;
    } pls_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] value_out;
        logic [POS_W-1:0]        found_position;
        logic [POS_W-1:0]        list_length;
        logic                    list_empty;
    } pls_rsp_t;

    // Engine status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } pls_eng_stat_t;

endpackage

[hw/rtl/pls_stream_if.sv]
interface pls_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/positional_list_store_core.sv]
// Operation: insert at position p shifts the entries from the tail down to p, then writes
//   the new word; delete reads entry p, then moves the later entries up; searches scan from the head.
// Throughput: one request at a time; the element memory port walks one entry per cycle.
//   A new request is taken while the previous response still waits in the output register.
// Reset: rst_n asynchronous, active low; the list comes up empty, no clearing pass.
module positional_list_store_core
    import pls_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    pls_stream_if.sink   req,
    pls_stream_if.source rsp
);

    pls_eng_stat_t eng_stat;
    pls_rsp_t      eng_res;
    logic          start;
    logic          res_take;

    logic          out_valid_reg;
    pls_rsp_t      out_data_reg;

    // Accept a request word only while the engine sits idle
    assign req.ready = eng_stat.idle;
    assign start     = req.valid && req.ready;

    // Move a finished result into the output register once it is free or draining
    assign res_take  = eng_stat.done && (!out_valid_reg || rsp.ready);

    pls_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req.payload),
        .take  (res_take),
        .stat  (eng_stat),
        .res   (eng_res)
    );

    // Output register: hold the response word until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= eng_res;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    // The engine never takes a new request while a result is pending inside it
    a_busy_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        eng_stat.done |-> !req.ready)
        else $error("request accepted while engine result pending");

    // A result handed over shows up on the output next cycle
    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> rsp.valid)
        else $error("taken result missing on output");

    // A full report means the list really holds CAPACITY words
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.status == ST_FULL) |->
        (rsp.payload.list_length == POS_W'(CAPACITY) && !rsp.payload.list_empty))
        else $error("full status with wrong length");

    // Only a successful search reports a position
    a_fpos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.found_position != '0) |-> rsp.payload.status == ST_OK)
        else $error("found position with error status");

endmodule

[hw/rtl/pls_engine.sv]
module pls_engine
    import pls_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pls_req_t      req,
    input  logic          take,
    output pls_eng_stat_t stat,
    output pls_rsp_t      res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_INS_SHIFT = 9'b000000010,
        S_INS_PUT   = 9'b000000100,
        S_DEL_GET   = 9'b000001000,
        S_DEL_SHIFT = 9'b000010000,
        S_RD_WAIT   = 9'b000100000,
        S_SEARCH    = 9'b001000000,
        S_NB_WAIT   = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         k_reg, k_next;
    logic [AW-1:0]         last_reg, last_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [VAL_W-1:0]      val_reg, val_next;
    logic [VAL_W-1:0]      prev_reg, prev_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [VAL_W-1:0]      vout_reg, vout_next;
    logic [POS_W-1:0]      fpos_reg, fpos_next;

    // Element store: one write port, one registered read port
    logic [VAL_W-1:0]      mem [CAPACITY];
    logic [AW-1:0]         rd_addr;
    logic [VAL_W-1:0]      rd_data_reg;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VAL_W-1:0]      wr_data;

    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic [AW-1:0]         req_k;
    logic [AW-1:0]         cnt_last;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign pos_ext  = PW'(req.position);
    assign cnt_ext  = PW'(count_reg);
    assign req_k    = AW'(pos_ext - PW'(1));
    assign cnt_last = AW'(cnt_ext - PW'(1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        last_next   = last_reg;
        mode_next   = mode_reg;
        val_next    = val_reg;
        prev_next   = prev_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        fpos_next   = fpos_reg;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = req.mode;
                    val_next    = req.value_in;
                    status_next = ST_OK;
                    vout_next   = '0;
                    fpos_next   = '0;
                    k_next      = req_k;
                    last_next   = cnt_last;
                    state_next  = S_DONE;
                    case (req.mode)
                        MODE_INSERT:
                        begin
                            if (pos_ext == '0 || pos_ext > cnt_ext + PW'(1))
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else if (cnt_ext >= PW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_ext == cnt_ext + PW'(1))
                            begin
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                // start the shift from the tail
                                rd_addr    = cnt_last;
                                idx_next   = cnt_last;
                                state_next = S_INS_SHIFT;
                            end
                        end
                        MODE_DELETE, MODE_READ:
                        begin
                            if (pos_ext == '0 || pos_ext > cnt_ext)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                rd_addr    = req_k;
                                state_next = (req.mode == MODE_DELETE) ? S_DEL_GET : S_RD_WAIT;
                            end
                        end
                        MODE_LOCATE, MODE_PRIOR, MODE_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_INS_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                wr_data = rd_data_reg;
                if (idx_reg == k_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    rd_addr  = idx_reg - AW'(1);
                    idx_next = idx_reg - AW'(1);
                end
            end

            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = k_reg;
                wr_data    = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            S_DEL_GET:
            begin
                vout_next = rd_data_reg;
                if (k_reg == last_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = k_reg + AW'(1);
                    idx_next   = k_reg + AW'(1);
                    state_next = S_DEL_SHIFT;
                end
            end

            S_DEL_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg - AW'(1);
                wr_data = rd_data_reg;
                if (idx_reg == last_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_RD_WAIT:
            begin
                vout_next  = rd_data_reg;
                state_next = S_DONE;
            end

            S_SEARCH:
            begin
                if (rd_data_reg == val_reg)
                begin
                    state_next = S_DONE;
                    case (mode_reg)
                        MODE_LOCATE:
                        begin
                            fpos_next = POS_W'(PW'(idx_reg) + PW'(1));
                        end
                        MODE_PRIOR:
                        begin
                            if (idx_reg == '0)
                            begin
                                status_next = ST_NO_NEIGHBOUR;
                            end
                            else
                            begin
                                vout_next = prev_reg;
                            end
                        end
                        default:
                        begin
                            if (idx_reg == last_reg)
                            begin
                                status_next = ST_NO_NEIGHBOUR;
                            end
                            else
                            begin
                                rd_addr    = idx_reg + AW'(1);
                                state_next = S_NB_WAIT;
                            end
                        end
                    endcase
                end
                else
                begin
                    prev_next = rd_data_reg;
                    if (idx_reg == last_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        rd_addr  = idx_reg + AW'(1);
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end

            S_NB_WAIT:
            begin
                vout_next  = rd_data_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        last_reg   <= last_next;
        mode_reg   <= mode_next;
        val_reg    <= val_next;
        prev_reg   <= prev_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        fpos_reg   <= fpos_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);

    assign res.status         = status_reg;
    assign res.value_out      = vout_reg;
    assign res.found_position = fpos_reg;
    assign res.list_length    = POS_W'(count_reg);
    assign res.list_empty     = (count_reg == '0);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import pls_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_WORDS = 1176;
    localparam int CYCLE_LIMIT  = 600000;
    // Longest walk in the engine plus the output register, with some slack.
    localparam int SETTLE_CYCLES = CAPACITY + 16;
    // Long receiver hold-off, so that the core fills up and stalls its input.
    localparam int LONG_HOLD = 500;

    // Mode 7 has no operation behind it; the core must answer ok and change nothing.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    typedef struct {
        pls_req_t word;
        bit       drain;   // wait until every answer is back before sending
        bit       calm;    // last stretch of the run: no idling on either side
    } planned_word_t;

    logic clk = 1'b0;
    logic rst_n;

    pls_stream_if #(.payload_t(pls_req_t)) req_if ();
    pls_stream_if #(.payload_t(pls_rsp_t)) rsp_if ();

    positional_list_store_core #(.CAPACITY(CAPACITY)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // List predictor: its own copy of the packed element array and count.
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] shadow_elems [CAPACITY];
    int unsigned             shadow_len;

    pls_rsp_t       expected_rsp [$];
    planned_word_t  pending_words [$];

    int  failures;
    int  words_sent;
    int  rsp_checked;
    int  full_hits;
    int  bad_pos_hits;
    int  miss_hits;
    int  edge_hits;
    bit  calm_tail;

    // Index of the first entry equal to v, or the current length when absent.
    function automatic int unsigned first_hit(logic signed [VAL_W-1:0] v);
        int unsigned k;
        for (k = 0; k < shadow_len; k++)
            if (shadow_elems[k] == v)
                return k;
        return shadow_len;
    endfunction

    // Apply one request to the shadow list and return the answer it must produce.
    function automatic pls_rsp_t apply_list_request(pls_req_t r);
        pls_rsp_t    a;
        int unsigned k;
        int unsigned i;
        a = '0;
        a.status = ST_OK;
        case (r.mode)
            MODE_INSERT:
            begin
                if (r.position < 1 || r.position > shadow_len + 1)
                    a.status = ST_BAD_POS;
                else if (shadow_len >= CAPACITY)
                    a.status = ST_FULL;
                else
                begin
                    k = r.position - 1;
                    for (i = shadow_len; i > k; i--)
                        shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[k] = r.value_in;
                    shadow_len++;
                end
            end
            MODE_DELETE:
            begin
                if (r.position < 1 || r.position > shadow_len)
                    a.status = ST_BAD_POS;
                else
                begin
                    k = r.position - 1;
                    a.value_out = shadow_elems[k];
                    for (i = k; i + 1 < shadow_len; i++)
                        shadow_elems[i] = shadow_elems[i+1];
                    shadow_len--;
                end
            end
            MODE_READ:
            begin
                if (r.position < 1 || r.position > shadow_len)
                    a.status = ST_BAD_POS;
                else
                    a.value_out = shadow_elems[r.position - 1];
            end
            MODE_LOCATE:
            begin
                k = first_hit(r.value_in);
                if (k >= shadow_len)
                    a.status = ST_NOT_FOUND;
                else
                    a.found_position = POS_W'(k + 1);
            end
            MODE_PRIOR:
            begin
                k = first_hit(r.value_in);
                if (k >= shadow_len)
                    a.status = ST_NOT_FOUND;
                else if (k == 0)
                    a.status = ST_NO_NEIGHBOUR;
                else
                    a.value_out = shadow_elems[k-1];
            end
            MODE_NEXT:
            begin
                k = first_hit(r.value_in);
                if (k >= shadow_len)
                    a.status = ST_NOT_FOUND;
                else if (k + 1 >= shadow_len)
                    a.status = ST_NO_NEIGHBOUR;
                else
                    a.value_out = shadow_elems[k+1];
            end
            MODE_CLEAR:
                shadow_len = 0;
            default:
                ;
        endcase
        a.list_length = POS_W'(shadow_len);
        a.list_empty  = (shadow_len == 0);
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: feeds words from the pending queue, with idle bursts.
    // Valid is only ever assigned once per edge, and held while stalled.
    // ------------------------------------------------------------------
    int            send_gap;
    planned_word_t next_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
            send_gap = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                // Predict at acceptance, so the shadow list advances in request order.
                expected_rsp.push_back(apply_list_request(req_if.payload));
                words_sent++;
                if (!calm_tail && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 16);
            end
            // A word still waiting for ready is left untouched.
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_words.size() == 0 ||
                         (pending_words[0].drain && expected_rsp.size() != 0))
                    req_if.valid <= 1'b0;
                else
                begin
                    next_word = pending_words.pop_front();
                    req_if.payload <= next_word.word;
                    req_if.valid   <= 1'b1;
                    if (next_word.calm)
                        calm_tail <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: checks every accepted answer against the oldest
    // expectation, and drives ready with bursts and one long hold-off.
    // ------------------------------------------------------------------
    int       recv_hold;
    bit       long_hold_done;
    pls_rsp_t want;
    pls_rsp_t got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.payload;
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected response word: status %0d value_out %0d",
                           got.status, got.value_out);
                    failures++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    rsp_checked++;
                    case (want.status)
                        ST_FULL:         full_hits++;
                        ST_BAD_POS:      bad_pos_hits++;
                        ST_NOT_FOUND:    miss_hits++;
                        ST_NO_NEIGHBOUR: edge_hits++;
                        default:         ;
                    endcase
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        failures++;
                    end
                    if (got.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %0d actual %0d",
                               want.value_out, got.value_out);
                        failures++;
                    end
                    if (got.found_position !== want.found_position)
                    begin
                        $error("found_position: expected %0d actual %0d",
                               want.found_position, got.found_position);
                        failures++;
                    end
                    if (got.list_length !== want.list_length)
                    begin
                        $error("list_length: expected %0d actual %0d",
                               want.list_length, got.list_length);
                        failures++;
                    end
                    if (got.list_empty !== want.list_empty)
                    begin
                        $error("list_empty: expected %0d actual %0d",
                               want.list_empty, got.list_empty);
                        failures++;
                    end
                end
            end

            if (recv_hold > 0)
            begin
                recv_hold--;
                rsp_if.ready <= 1'b0;
            end
            else if (!long_hold_done && rsp_checked >= 350)
            begin
                // Hold off while the driver keeps offering words.
                long_hold_done = 1'b1;
                recv_hold = LONG_HOLD - 1;
                rsp_if.ready <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 7) == 0)
            begin
                recv_hold = $urandom_range(0, 15);
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus planning. plan_len tracks the length the list will have,
    // only so that positions can be aimed inside or just outside it.
    // ------------------------------------------------------------------
    int unsigned plan_len;

    task automatic plan_word(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                             input logic [VAL_W-1:0] v, input bit drain, input bit calm);
        planned_word_t w;
        w.word.mode     = m;
        w.word.position = p;
        w.word.value_in = v;
        w.drain         = drain;
        w.calm          = calm;
        pending_words.push_back(w);
        case (m)
            MODE_INSERT:
                if (p >= 1 && p <= plan_len + 1 && plan_len < CAPACITY)
                    plan_len++;
            MODE_DELETE:
                if (p >= 1 && p <= plan_len)
                    plan_len--;
            MODE_CLEAR:
                plan_len = 0;
            default:
                ;
        endcase
    endtask

    // Cumulative weights per mode, in the order of mode_order; the rest is mode 7.
    logic [MODE_W-1:0] mode_order [7];
    int                mix_cut    [7];
    int                grow_cut   [7];
    logic [VAL_W-1:0]  value_pool [8];

    initial
    begin
        int unsigned      n;
        int               i;
        int               r;
        int unsigned      limit;
        bit               growing;
        logic [MODE_W-1:0] m;
        logic [POS_W-1:0]  p;
        logic [VAL_W-1:0]  v;

        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        rst_n          = 1'b0;
        shadow_len     = 0;
        plan_len       = 0;
        failures       = 0;
        words_sent     = 0;
        rsp_checked    = 0;
        full_hits      = 0;
        bad_pos_hits   = 0;
        miss_hits      = 0;
        edge_hits      = 0;
        calm_tail      = 1'b0;
        long_hold_done = 1'b0;

        mode_order = '{MODE_INSERT, MODE_DELETE, MODE_READ, MODE_LOCATE,
                       MODE_PRIOR, MODE_NEXT, MODE_CLEAR};
        mix_cut    = '{35, 52, 64, 76, 86, 96, 98};
        // Growth blocks drive the list to full and keep pushing against it.
        grow_cut   = '{82, 88, 91, 94, 97, 100, 100};

        // Small pool with the extremes, so searches hit and duplicates appear.
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        // Directed: empty-list errors, extremes, neighbours at both ends.
        plan_word(MODE_READ,   1, 32'd0, 0, 0);     // read on an empty list
        plan_word(MODE_DELETE, 0, 32'd0, 0, 0);
        plan_word(MODE_LOCATE, 0, 32'd5, 0, 0);     // searches miss on empty
        plan_word(MODE_PRIOR,  0, 32'd5, 0, 0);
        plan_word(MODE_NEXT,   0, 32'd5, 0, 0);
        plan_word(MODE_INSERT, 0, 32'd9, 0, 0);     // position zero
        plan_word(MODE_INSERT, 2, 32'd9, 0, 0);     // past length+1
        plan_word(MODE_INSERT, 1, 32'h8000_0000, 0, 0);
        plan_word(MODE_INSERT, 2, 32'h7FFF_FFFF, 0, 0);   // append
        plan_word(MODE_INSERT, 1, 32'hFFFF_FFFF, 0, 0);   // push front
        plan_word(MODE_INSERT, 2, 32'h0000_0000, 0, 0);   // middle
        plan_word(MODE_READ,   4, 32'd0, 0, 0);
        plan_word(MODE_READ,   5, 32'd0, 0, 0);     // one past the end
        plan_word(MODE_LOCATE, 0, 32'h7FFF_FFFF, 0, 0);
        plan_word(MODE_PRIOR,  0, 32'hFFFF_FFFF, 0, 0);   // match at the head
        plan_word(MODE_NEXT,   0, 32'h7FFF_FFFF, 0, 0);   // match at the tail
        plan_word(MODE_PRIOR,  0, 32'h8000_0000, 0, 0);
        plan_word(MODE_NEXT,   0, 32'hFFFF_FFFF, 0, 0);
        plan_word(MODE_DELETE, 4, 32'd0, 0, 0);     // delete the tail
        plan_word(MODE_DELETE, 1, 32'd0, 0, 0);     // delete the head
        plan_word(MODE_UNUSED, 7'h7F, 32'hFFFF_FFFF, 0, 0);
        plan_word(MODE_READ,   7'h7F, 32'd0, 0, 0);
        plan_word(MODE_CLEAR,  0, 32'd0, 0, 0);
        plan_word(MODE_READ,   1, 32'd0, 0, 0);     // read after clear

        // Random: mostly well-aimed positions and pooled values, some noise.
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            growing = ((n / 100) % 4 == 1);
            r = $urandom_range(0, 99);
            m = MODE_UNUSED;
            for (i = 6; i >= 0; i--)
                if (r < (growing ? grow_cut[i] : mix_cut[i]))
                    m = mode_order[i];

            limit = (m == MODE_INSERT) ? plan_len + 1 : plan_len;
            if (m == MODE_INSERT || m == MODE_DELETE || m == MODE_READ)
            begin
                if ($urandom_range(0, 99) < 85 && limit >= 1)
                    p = POS_W'($urandom_range(1, limit));
                else if ($urandom_range(0, 1) == 0)
                    p = '0;
                else
                    p = POS_W'($urandom_range(limit + 1, 127));
            end
            else
                p = POS_W'($urandom_range(0, 127));

            if ($urandom_range(0, 99) < ((m == MODE_INSERT) ? 60 : 75))
                v = value_pool[$urandom_range(0, 7)];
            else
                v = $urandom;

            plan_word(m, p, v, (n == 600), (n >= RANDOM_WORDS - 150));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || req_if.valid)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        // Let any stray answer show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_rsp.size() != 0)
        begin
            $error("%0d expected response words never arrived", expected_rsp.size());
            failures++;
        end

        $display("Covered %0d request words over all modes and the unused code;",
                 words_sent);
        $display("%0d answers checked, %0d full, %0d bad positions, %0d misses, %0d at an end.",
                 rsp_checked, full_hits, bad_pos_hits, miss_hits, edge_hits);
        if (failures == 0)
            $display("positional_list_store_core: match");
        else
            $display("positional_list_store_core: mismatch");
        $finish;
    end

    // Watchdog on a cycle count.
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d answers outstanding.",
                 cycles, expected_rsp.size());
        $display("positional_list_store_core: mismatch");
        $finish;
    end

endmodule

[positional_list_store_core.f]
hw/rtl/pls_pkg.sv
hw/rtl/pls_stream_if.sv
hw/rtl/pls_engine.sv
hw/rtl/positional_list_store_core.sv
tb/testbench.sv
